FILE: sv/jpeg_marker_stream_splitter_macros.svh
// Assertion macros shared by the splitter modules.
`ifndef JPEG_MARKER_STREAM_SPLITTER_MACROS_SVH
`define JPEG_MARKER_STREAM_SPLITTER_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define JMSS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define JMSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/jmss_pkg.sv
package jmss_pkg;

    // Parser phases.
    localparam logic [2:0] PH_TOP   = 3'd0;
    localparam logic [2:0] PH_LENHI = 3'd1;
    localparam logic [2:0] PH_LENLO = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_SCAN  = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_BODY = 2'd1;
    localparam logic [1:0] KIND_OK   = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_SAFE_MODE     = 1'b0;
    localparam logic CFG_HEADER_ENABLE = 1'b1;

    // Marker bytes.
    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] ID_SOI    = 8'hD8;
    localparam logic [7:0] ID_EOI    = 8'hD9;
    localparam logic [7:0] ID_SOS    = 8'hDA;
    localparam logic [3:0] RST_HIGH  = 4'hD;
    localparam logic [15:0] TALLY_MAX = 16'hFFFF;

    // Result queue geometry.
    localparam int RB_DEPTH = 4;
    localparam int RB_PTR_W = 2;
    localparam int RB_CNT_W = 3;

    typedef struct packed {
        logic safe_mode;
        logic header_enable;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] rc;
    } result_t;

    // Results of one accepted beat, r0 first.
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_t;

endpackage

FILE: sv/jpeg_marker_stream_splitter.sv
// Results: a beat's results are written into a 4-entry result queue when the beat is accepted;
// the single output port drains the queue. Throughput: one input beat per cycle while the
// queue holds at most two results; beats with two results fill it faster than it drains.
// Reset: rst_n is asynchronous and active low; it clears the parser state and the queue,
// and sets safe_mode to 0 and header_enable to 1.
module jpeg_marker_stream_splitter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic [15:0] restart_count
);

    jmss_pkg::cfg_t    cfg_reg;
    jmss_pkg::step_t   step;
    jmss_pkg::result_t head;
    logic              room;
    logic              step_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.safe_mode     <= 1'b0;
            cfg_reg.header_enable <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                jmss_pkg::CFG_SAFE_MODE:     cfg_reg.safe_mode     <= cfg_data;
                jmss_pkg::CFG_HEADER_ENABLE: cfg_reg.header_enable <= cfg_data;
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    assign in_ready = room;
    assign step_en  = in_valid && room;

    jmss_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .step_en       (step_en),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .step          (step)
    );

    jmss_rbuf u_rbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign out_kind      = head.kind;
    assign out_byte      = head.data;
    assign restart_count = head.rc;

endmodule

FILE: sv/jmss_parser.sv
module jmss_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  jmss_pkg::cfg_t      cfg,
    input  logic                step_en,
    input  logic [7:0]          data_byte,
    input  logic                end_of_stream,
    output jmss_pkg::step_t     step
);

    logic [2:0]  phase_reg, phase_next;
    logic        ff_reg, ff_next;
    logic        scan_reg, scan_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] tally_reg, tally_next;
    logic        halted_reg, halted_next;

    jmss_pkg::result_t e0, e1;
    logic              e0_v, e1_v;
    logic              do_marker;
    logic              do_finish;
    logic              seg_hdr;
    logic              seg_emit;
    logic [1:0]        seg_kind;
    logic              mk_scan;
    logic              mk_hdr;
    logic              mk_emit;
    logic [1:0]        mk_kind;
    logic              is_rst;
    logic [15:0]       seg_len;

    always_comb
    begin
        is_rst  = (data_byte[7:4] == jmss_pkg::RST_HIGH) && !data_byte[3];
        seg_len = {len_hi_reg, data_byte};

        // Routing of segment bytes for the segment already open.
        seg_hdr  = !(scan_reg && !cfg.safe_mode);
        seg_emit = !seg_hdr || cfg.header_enable;
        seg_kind = seg_hdr ? jmss_pkg::KIND_HDR : jmss_pkg::KIND_BODY;

        // Routing for a segment that a marker in this beat opens.
        mk_scan = (data_byte == jmss_pkg::ID_SOS);
        mk_hdr  = !(mk_scan && !cfg.safe_mode);
        mk_emit = !mk_hdr || cfg.header_enable;
        mk_kind = mk_hdr ? jmss_pkg::KIND_HDR : jmss_pkg::KIND_BODY;

        phase_next  = phase_reg;
        ff_next     = ff_reg;
        scan_next   = scan_reg;
        len_hi_next = len_hi_reg;
        rem_next    = rem_reg;
        tally_next  = tally_reg;
        halted_next = halted_reg;
        e0          = '0;
        e1          = '0;
        e0_v        = 1'b0;
        e1_v        = 1'b0;
        do_marker   = 1'b0;
        do_finish   = 1'b0;

        if (halted_reg)
        begin
            halted_next = 1'b1;
        end
        else if (end_of_stream)
        begin
            halted_next = 1'b1;
            e0_v    = 1'b1;
            e0.kind = (phase_reg == jmss_pkg::PH_TOP) ? jmss_pkg::KIND_OK
                                                      : jmss_pkg::KIND_ERR;
            e0.rc   = tally_reg;
        end
        else
        begin
            unique case (phase_reg)
                jmss_pkg::PH_TOP:
                begin
                    if (ff_reg)
                        do_marker = 1'b1;
                    else
                        ff_next = (data_byte == jmss_pkg::BYTE_FF);
                end
                jmss_pkg::PH_LENHI:
                begin
                    len_hi_next = data_byte;
                    e0_v        = seg_emit;
                    e0.kind     = seg_kind;
                    e0.data     = data_byte;
                    phase_next  = jmss_pkg::PH_LENLO;
                end
                jmss_pkg::PH_LENLO:
                begin
                    e0_v    = seg_emit;
                    e0.kind = seg_kind;
                    e0.data = data_byte;
                    if (seg_len < 16'd2)
                    begin
                        // Length shorter than its own field: fail right away.
                        halted_next = 1'b1;
                        e1_v        = 1'b1;
                        e1.kind     = jmss_pkg::KIND_ERR;
                        e1.rc       = tally_reg;
                    end
                    else
                    begin
                        rem_next = seg_len - 16'd2;
                        if (seg_len == 16'd2)
                            do_finish = 1'b1;
                        else
                            phase_next = jmss_pkg::PH_DATA;
                    end
                end
                jmss_pkg::PH_DATA:
                begin
                    e0_v     = seg_emit;
                    e0.kind  = seg_kind;
                    e0.data  = data_byte;
                    rem_next = rem_reg - 16'd1;
                    if (rem_reg == 16'd1)
                        do_finish = 1'b1;
                end
                jmss_pkg::PH_SCAN:
                begin
                    if (ff_reg)
                    begin
                        if ((data_byte == jmss_pkg::BYTE_ZERO) || is_rst)
                        begin
                            e0_v    = 1'b1;
                            e0.kind = jmss_pkg::KIND_BODY;
                            e0.data = jmss_pkg::BYTE_FF;
                            e1_v    = 1'b1;
                            e1.kind = jmss_pkg::KIND_BODY;
                            e1.data = data_byte;
                            if (is_rst && (tally_reg != jmss_pkg::TALLY_MAX))
                                tally_next = tally_reg + 16'd1;
                            ff_next = 1'b0;
                        end
                        else
                        begin
                            do_marker = 1'b1;
                        end
                    end
                    else
                    begin
                        e0_v    = (data_byte != jmss_pkg::BYTE_FF);
                        e0.kind = jmss_pkg::KIND_BODY;
                        e0.data = data_byte;
                        ff_next = (data_byte == jmss_pkg::BYTE_FF);
                    end
                end
                default:
                begin
                    phase_next = jmss_pkg::PH_TOP;
                    ff_next    = 1'b0;
                end
            endcase

            if (do_finish)
            begin
                ff_next = 1'b0;
                if (scan_reg)
                begin
                    tally_next = 16'd1;
                    phase_next = jmss_pkg::PH_SCAN;
                end
                else
                begin
                    phase_next = jmss_pkg::PH_TOP;
                end
            end

            if (do_marker)
            begin
                ff_next    = 1'b0;
                phase_next = jmss_pkg::PH_TOP;
                priority if (data_byte == jmss_pkg::ID_EOI)
                begin
                    // End of image is dropped.
                end
                else if (data_byte == jmss_pkg::ID_SOI)
                begin
                    e0_v    = cfg.header_enable;
                    e0.kind = jmss_pkg::KIND_HDR;
                    e0.data = jmss_pkg::BYTE_FF;
                    e1_v    = cfg.header_enable;
                    e1.kind = jmss_pkg::KIND_HDR;
                    e1.data = jmss_pkg::ID_SOI;
                end
                else
                begin
                    scan_next  = mk_scan;
                    e0_v       = mk_emit;
                    e0.kind    = mk_kind;
                    e0.data    = jmss_pkg::BYTE_FF;
                    e1_v       = mk_emit;
                    e1.kind    = mk_kind;
                    e1.data    = data_byte;
                    phase_next = jmss_pkg::PH_LENHI;
                end
            end
        end

        // Pack the results so that the first one present sits in r0.
        step.count = {1'b0, e0_v} + {1'b0, e1_v};
        step.r0    = e0_v ? e0 : e1;
        step.r1    = e1;
        if (!step_en)
            step.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= jmss_pkg::PH_TOP;
            ff_reg     <= 1'b0;
            scan_reg   <= 1'b0;
            len_hi_reg <= 8'd0;
            rem_reg    <= 16'd0;
            tally_reg  <= 16'd0;
            halted_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            ff_reg     <= ff_next;
            scan_reg   <= scan_next;
            len_hi_reg <= len_hi_next;
            rem_reg    <= rem_next;
            tally_reg  <= tally_next;
            halted_reg <= halted_next;
        end
    end

`include "jpeg_marker_stream_splitter_macros.svh"

    `JMSS_ASSERT_NEXT(a_halt_sticky, halted_reg, halted_reg, "halted state was left")
    `JMSS_ASSERT_NEXT(a_status_halts, step.count != 2'd0 && step.r0.kind[1], halted_reg, "status without halt")

endmodule

FILE: sv/jmss_rbuf.sv
module jmss_rbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  jmss_pkg::step_t     step,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output jmss_pkg::result_t   head
);

    jmss_pkg::result_t mem [jmss_pkg::RB_DEPTH];

    logic [jmss_pkg::RB_PTR_W-1:0] wptr_reg, wptr_next;
    logic [jmss_pkg::RB_PTR_W-1:0] rptr_reg, rptr_next;
    logic [jmss_pkg::RB_CNT_W-1:0] count_reg, count_next;
    logic [jmss_pkg::RB_PTR_W-1:0] wptr_plus1;
    logic                          pop;

    always_comb
    begin
        out_valid  = (count_reg != '0);
        head       = mem[rptr_reg];
        pop        = out_valid && out_ready;
        // Room for the two results one beat can cause.
        room       = (count_reg <= jmss_pkg::RB_CNT_W'(jmss_pkg::RB_DEPTH - 2));
        wptr_plus1 = wptr_reg + jmss_pkg::RB_PTR_W'(1);
        wptr_next  = wptr_reg + jmss_pkg::RB_PTR_W'(step.count);
        rptr_next  = rptr_reg + jmss_pkg::RB_PTR_W'(pop);
        count_next = count_reg + jmss_pkg::RB_CNT_W'(step.count)
                     - jmss_pkg::RB_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (step.count != 2'd0)
            mem[wptr_reg] <= step.r0;
        if (step.count == 2'd2)
            mem[wptr_plus1] <= step.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

`include "jpeg_marker_stream_splitter_macros.svh"

    `JMSS_ASSERT_ALWAYS(a_no_overflow, (32'(count_reg) + 32'(step.count)) <= jmss_pkg::RB_DEPTH, "result queue overflow")
    `JMSS_ASSERT_NEXT(a_pop_drains, pop && step.count == 2'd0, count_reg == $past(count_reg) - jmss_pkg::RB_CNT_W'(1), "pop did not drain")

endmodule

FILE: tb/tb_jpeg_marker_stream_splitter.sv
module tb_jpeg_marker_stream_splitter;
    timeunit 1ns;
    timeprecision 1ps;

    import jmss_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic        cfg_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_stream = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [15:0] restart_count;

    // Parser state mirrored by the stream predictor.
    logic        cfg_safe = 1'b0;
    logic        cfg_hdr_en = 1'b1;
    logic [2:0]  ps_phase = PH_TOP;
    logic        ps_prev_ff = 1'b0;
    logic        ps_in_scan = 1'b0;
    logic        ps_halted = 1'b0;
    logic [7:0]  ps_len_high = 8'h00;
    logic [15:0] ps_remaining = 16'h0000;
    logic [15:0] ps_tally = 16'h0000;

    result_t     expected_results[$];
    result_t     want;
    beat_t       pending_beats[$];
    beat_t       head_beat;
    int          generated = 0;
    logic        gen_in_scan = 1'b0;
    logic        quiet = 1'b0;
    int          idle_left = 0;
    int          stall_left = 0;
    int          errors = 0;

    jpeg_marker_stream_splitter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_kind      (out_kind),
        .out_byte      (out_byte),
        .restart_count (restart_count)
    );

    always #4 clk = ~clk;

    function automatic logic is_rst(input logic [7:0] b);
        return (b[7:4] == RST_HIGH) && !b[3];
    endfunction

    function automatic void push_result(input logic [1:0] kind, input logic [7:0] b,
                                        input logic [15:0] rc);
        result_t r;
        r.kind = kind;
        r.data = b;
        r.rc   = rc;
        expected_results.push_back(r);
    endfunction

    function automatic void push_header_byte(input logic [7:0] b);
        if (cfg_hdr_en)
            push_result(KIND_HDR, b, '0);
    endfunction

    function automatic void push_segment_byte(input logic [7:0] b);
        if (ps_in_scan && !cfg_safe)
            push_result(KIND_BODY, b, '0);
        else
            push_header_byte(b);
    endfunction

    function automatic void close_segment();
        ps_prev_ff = 1'b0;
        if (ps_in_scan) begin
            ps_tally = 16'd1;
            ps_phase = PH_SCAN;
        end
        else begin
            ps_phase = PH_TOP;
        end
    endfunction

    function automatic void open_marker(input logic [7:0] id);
        ps_prev_ff = 1'b0;
        ps_phase = PH_TOP;
        if (id == ID_SOI) begin
            push_header_byte(BYTE_FF);
            push_header_byte(ID_SOI);
        end
        else if (id != ID_EOI) begin
            ps_in_scan = (id == ID_SOS);
            push_segment_byte(BYTE_FF);
            push_segment_byte(id);
            ps_phase = PH_LENHI;
        end
    endfunction

    function automatic void predict_beat(input logic [7:0] b, input logic eos);
        logic [15:0] seg_len;
        if (ps_halted)
            return;
        if (eos) begin
            ps_halted = 1'b1;
            push_result((ps_phase == PH_TOP) ? KIND_OK : KIND_ERR, BYTE_ZERO, ps_tally);
            return;
        end
        case (ps_phase)
            PH_TOP: begin
                if (ps_prev_ff)
                    open_marker(b);
                else
                    ps_prev_ff = (b == BYTE_FF);
            end
            PH_LENHI: begin
                ps_len_high = b;
                push_segment_byte(b);
                ps_phase = PH_LENLO;
            end
            PH_LENLO: begin
                push_segment_byte(b);
                seg_len = {ps_len_high, b};
                if (seg_len < 16'd2) begin
                    ps_halted = 1'b1;
                    push_result(KIND_ERR, BYTE_ZERO, ps_tally);
                end
                else begin
                    ps_remaining = seg_len - 16'd2;
                    if (ps_remaining == 16'd0)
                        close_segment();
                    else
                        ps_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                push_segment_byte(b);
                ps_remaining = ps_remaining - 16'd1;
                if (ps_remaining == 16'd0)
                    close_segment();
            end
            PH_SCAN: begin
                if (ps_prev_ff) begin
                    if (b == BYTE_ZERO || is_rst(b)) begin
                        push_result(KIND_BODY, BYTE_FF, '0);
                        push_result(KIND_BODY, b, '0);
                        if (is_rst(b) && ps_tally != TALLY_MAX)
                            ps_tally = ps_tally + 16'd1;
                        ps_prev_ff = 1'b0;
                    end
                    else begin
                        open_marker(b);
                    end
                end
                else begin
                    if (b != BYTE_FF)
                        push_result(KIND_BODY, b, '0);
                    ps_prev_ff = (b == BYTE_FF);
                end
            end
            default: begin
                ps_phase = PH_TOP;
                ps_prev_ff = 1'b0;
            end
        endcase
    endfunction

    function automatic void queue_beat(input logic [7:0] b, input logic eos);
        beat_t t;
        t.data = b;
        t.eos  = eos;
        pending_beats.push_back(t);
        generated++;
    endfunction

    function automatic void queue_byte(input logic [7:0] b);
        queue_beat(b, 1'b0);
    endfunction

    // A marker id that opens a length-prefixed segment. Right after scan data the
    // stuffing and restart codes would not end the scan, so they are left out there.
    function automatic logic [7:0] pick_marker_id(input logic after_scan);
        logic [7:0] id;
        do
            id = 8'($urandom_range(0, 255));
        while (id == ID_SOI || id == ID_EOI || id == ID_SOS
               || (after_scan && (id == BYTE_ZERO || is_rst(id))));
        return id;
    endfunction

    function automatic void queue_segment(input logic [7:0] id, input logic [15:0] seg_len);
        int i;
        queue_byte(BYTE_FF);
        queue_byte(id);
        queue_byte(seg_len[15:8]);
        queue_byte(seg_len[7:0]);
        for (i = 0; i < int'(seg_len) - 2; i++)
            queue_byte(8'($urandom_range(0, 255)));
        gen_in_scan = (id == ID_SOS);
    endfunction

    function automatic void queue_scan_data(input int atoms);
        int i;
        int r;
        for (i = 0; i < atoms; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                queue_byte(8'($urandom_range(0, 254)));
            end
            else if (r < 85) begin
                queue_byte(BYTE_FF);
                queue_byte(BYTE_ZERO);
            end
            else begin
                queue_byte(BYTE_FF);
                queue_byte({RST_HIGH, 1'b0, 3'($urandom_range(0, 7))});
            end
        end
    endfunction

    // Mostly short segments; now and then one with a length above 255.
    function automatic logic [15:0] pick_length();
        if ($urandom_range(0, 59) == 0)
            return 16'($urandom_range(256, 600));
        return 16'($urandom_range(2, 12));
    endfunction

    function automatic void add_random_unit();
        int r;
        int i;
        logic [7:0] id;
        if (gen_in_scan) begin
            queue_scan_data($urandom_range(0, 24));
        end
        else if ($urandom_range(0, 99) < 15) begin
            for (i = 0; i < $urandom_range(1, 4); i++)
                queue_byte(8'($urandom_range(0, 254)));
        end
        r = $urandom_range(0, 99);
        if (r < 30)
            id = ID_SOS;
        else if (r < 36)
            id = ID_SOI;
        else if (r < 42)
            id = ID_EOI;
        else if (r < 48)
            id = BYTE_FF;
        else
            id = pick_marker_id(gen_in_scan);
        if (id == ID_SOI || id == ID_EOI) begin
            queue_byte(BYTE_FF);
            queue_byte(id);
            gen_in_scan = 1'b0;
        end
        else begin
            queue_segment(id, pick_length());
        end
    endfunction

    task automatic wait_drained(input int cap);
        int n;
        n = 0;
        while ((pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
               && n < cap) begin
            @(posedge clk);
            n++;
        end
        // A beat that causes no result may still be inside the block.
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(input logic safe, input logic hdr_en);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SAFE_MODE;
        cfg_data  <= safe;
        @(posedge clk);
        cfg_index <= CFG_HEADER_ENABLE;
        cfg_data  <= hdr_en;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_safe   = safe;
        cfg_hdr_en = hdr_en;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            idle_left <= 0;
        end
        else begin
            if (in_valid && in_ready)
                predict_beat(data_byte, end_of_stream);
            if (!in_valid || in_ready) begin
                if (idle_left > 0) begin
                    in_valid  <= 1'b0;
                    idle_left <= idle_left - 1;
                end
                else if (!quiet && pending_beats.size() != 0
                         && $urandom_range(0, 19) == 0) begin
                    in_valid  <= 1'b0;
                    idle_left <= $urandom_range(0, 9);
                end
                else if (pending_beats.size() != 0) begin
                    head_beat = pending_beats.pop_front();
                    in_valid      <= 1'b1;
                    data_byte     <= head_beat.data;
                    end_of_stream <= head_beat.eos;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d byte %02h restart_count %0d",
                           out_kind, out_byte, restart_count);
                    errors++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (out_kind !== want.kind) begin
                        $error("out_kind: expected %0d, actual %0d", want.kind, out_kind);
                        errors++;
                    end
                    if (out_byte !== want.data) begin
                        $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
                        errors++;
                    end
                    if (restart_count !== want.rc) begin
                        $error("restart_count: expected %0d, actual %0d",
                               want.rc, restart_count);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (!quiet && $urandom_range(0, 11) == 0) begin
                out_ready  <= 1'b0;
                stall_left <= $urandom_range(0, 9);
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [7:0] directed_bytes[$];
        int p;
        int goal;
        int choice;
        int i;
        logic safe;
        logic hdr_en;

        // Stray bytes, SOI, an application segment, EOI, a scan header, scan data
        // with stuffing and both restart extremes, and a doubled 0xFF ending the scan.
        directed_bytes = '{8'h00, 8'h7F, BYTE_FF, ID_SOI,
                           BYTE_FF, 8'hE0, 8'h00, 8'h03, 8'hAA,
                           BYTE_FF, ID_EOI,
                           BYTE_FF, ID_SOS, 8'h00, 8'h03, 8'h01,
                           8'h12, BYTE_FF, BYTE_ZERO, BYTE_FF, {RST_HIGH, 4'h0},
                           BYTE_FF, {RST_HIGH, 4'h7},
                           BYTE_FF, BYTE_FF, 8'h00, 8'h02};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        set_config(1'b0, 1'b1);
        foreach (directed_bytes[i])
            queue_byte(directed_bytes[i]);
        gen_in_scan = 1'b0;
        wait_drained(20000);

        for (p = 0; p < 5; p++) begin
            case (p)
                0: begin safe = 1'b1; hdr_en = 1'b1; end
                1: begin safe = 1'b0; hdr_en = 1'b0; end
                2: begin safe = 1'b1; hdr_en = 1'b0; end
                default: begin
                    safe   = 1'($urandom_range(0, 1));
                    hdr_en = 1'($urandom_range(0, 1));
                end
            endcase
            set_config(safe, hdr_en);
            if (p == 4)
                quiet = 1'b1;
            goal = generated + 230;
            while (generated < goal)
                add_random_unit();
            if (p == 4) begin
                // The stream ends once, in one of its possible places.
                choice = $urandom_range(0, 6);
                case (choice)
                    0, 1: begin
                        if (gen_in_scan) begin
                            queue_byte(BYTE_FF);
                            queue_byte(ID_EOI);
                        end
                        if (choice == 1)
                            queue_byte(BYTE_FF);
                    end
                    2: begin
                        queue_byte(BYTE_FF);
                        queue_byte(pick_marker_id(gen_in_scan));
                        queue_byte(8'($urandom_range(0, 255)));
                    end
                    3: begin
                        queue_byte(BYTE_FF);
                        queue_byte(pick_marker_id(gen_in_scan));
                        queue_byte(8'h00);
                        queue_byte(8'h10);
                        queue_scan_data(3);
                    end
                    4: begin
                        if (!gen_in_scan)
                            queue_segment(ID_SOS, 16'($urandom_range(2, 8)));
                        queue_scan_data($urandom_range(1, 10));
                    end
                    5: begin
                        queue_byte(BYTE_FF);
                        queue_byte(($urandom_range(0, 1) == 0)
                                   ? ID_SOS : pick_marker_id(gen_in_scan));
                        queue_byte(8'h00);
                        queue_byte(8'($urandom_range(0, 1)));
                    end
                    default: begin
                        // Scan header cut short: the restart tally keeps its old value.
                        queue_byte(BYTE_FF);
                        queue_byte(ID_SOS);
                        queue_byte(8'h00);
                        queue_byte(8'h08);
                        queue_byte(8'($urandom_range(0, 255)));
                    end
                endcase
                queue_beat(8'($urandom_range(0, 255)), 1'b1);
                // Once a status has gone out, the block stays silent.
                for (i = 0; i < 4; i++)
                    queue_byte(8'($urandom_range(0, 255)));
                queue_beat(8'($urandom_range(0, 255)), 1'b1);
            end
            wait_drained(20000);
        end

        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
